// ===== design/max_subarray_xor_trie_defines.svh =====
`ifndef MAX_SUBARRAY_XOR_TRIE_DEFINES_SVH
`define MAX_SUBARRAY_XOR_TRIE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MXT_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MXT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/mxt_pkg.sv =====
`default_nettype none

package mxt_pkg;

	localparam int VALUE_BITS = 30;
	localparam int NODE_COUNT = 65536;
	localparam int MAX_ITEMS = 4096;

	localparam int NODE_W = $clog2(NODE_COUNT);
	localparam int COUNT_W = NODE_W + 1;
	localparam int POS_W = $clog2(MAX_ITEMS) + 1;
	localparam int LVL_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

	localparam int IN_W = ((VALUE_BITS + 7) / 8) * 8;
	localparam int OUT_W = ((VALUE_BITS + 2 * POS_W + 1 + 7) / 8) * 8;

	// One trie node: both child links and the earliest position through it.
	typedef struct packed {
		logic [POS_W-1:0]  leaf;
		logic [NODE_W-1:0] c1;
		logic [NODE_W-1:0] c0;
	} node_t;

	typedef struct packed {
		logic              wr_en;
		logic [NODE_W-1:0] wr_addr;
		node_t             wr_data;
		logic              rd_en;
		logic [NODE_W-1:0] rd_addr;
	} mem_req_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] best;
		logic [POS_W-1:0]      left;
		logic [POS_W-1:0]      right;
		logic                  overflow;
		logic                  final_flag;
	} result_t;

endpackage

`default_nettype wire

// ===== design/mxt_node_ram.sv =====
`default_nettype none

module mxt_node_ram (
	input  wire logic             clk,
	input  wire mxt_pkg::mem_req_t req,
	output mxt_pkg::node_t        rd_data
);

	mxt_pkg::node_t mem_q [mxt_pkg::NODE_COUNT];
	mxt_pkg::node_t rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem_q[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== design/mxt_engine.sv =====
`default_nettype none

module mxt_engine (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             item_valid,
	output logic                                  item_ready,
	input  wire logic [mxt_pkg::VALUE_BITS-1:0]   item_value,
	input  wire logic                             item_last,
	output logic                                  res_valid,
	input  wire logic                             res_ready,
	output mxt_pkg::result_t                      result,
	output mxt_pkg::mem_req_t                     mem_req,
	input  wire mxt_pkg::node_t                   rd_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INSERT,
		ST_LEAF_WR,
		ST_QUERY,
		ST_LEAF,
		ST_DONE
	} state_t;

	localparam logic [mxt_pkg::LVL_W-1:0] TOP_LVL = mxt_pkg::LVL_W'(mxt_pkg::VALUE_BITS - 1);

	state_t                           state_q;
	logic [mxt_pkg::VALUE_BITS-1:0]   prefix_q;
	logic [mxt_pkg::POS_W-1:0]        position_q;
	logic [mxt_pkg::VALUE_BITS-1:0]   best_q;
	logic [mxt_pkg::POS_W-1:0]        left_q;
	logic [mxt_pkg::POS_W-1:0]        right_q;
	logic                             overflow_q;
	logic                             last_q;
	logic [mxt_pkg::COUNT_W-1:0]      nodes_q;
	logic [mxt_pkg::NODE_W-1:0]       root_c0_q;
	logic [mxt_pkg::NODE_W-1:0]       root_c1_q;
	logic [mxt_pkg::NODE_W-1:0]       cur_q;
	logic [mxt_pkg::LVL_W-1:0]        lvl_q;
	logic                             at_root_q;
	logic                             fresh_q;
	logic                             zero_walk_q;
	logic [mxt_pkg::VALUE_BITS-1:0]   acc_q;

	mxt_pkg::node_t                   entry;
	mxt_pkg::node_t                   entry_upd;
	logic [mxt_pkg::VALUE_BITS-1:0]   key;
	logic [mxt_pkg::POS_W-1:0]        walk_pos;
	logic                             bitv;
	logic [mxt_pkg::NODE_W-1:0]       slot;
	logic [mxt_pkg::NODE_W-1:0]       opp;
	logic [mxt_pkg::NODE_W-1:0]       fresh_idx;
	logic                             store_full;
	logic                             last_level;
	logic [mxt_pkg::POS_W-1:0]        cand_left;
	logic                             better;
	state_t                           ins_next;

	always_comb begin
		key = zero_walk_q ? '0 : prefix_q;
		walk_pos = zero_walk_q ? '0 : position_q;
		bitv = key[lvl_q];
		// root lives in flops, a node made this walk is known without a read
		entry = rd_data;
		if (at_root_q) begin
			entry.leaf = '0;
			entry.c0 = root_c0_q;
			entry.c1 = root_c1_q;
		end else if (fresh_q) begin
			entry = '0;
			entry.leaf = walk_pos;
		end
		slot = bitv ? entry.c1 : entry.c0;
		opp = bitv ? entry.c0 : entry.c1;
		fresh_idx = nodes_q[mxt_pkg::NODE_W-1:0];
		store_full = nodes_q >= mxt_pkg::COUNT_W'(mxt_pkg::NODE_COUNT);
		entry_upd = entry;
		if (bitv) begin
			entry_upd.c1 = fresh_idx;
		end else begin
			entry_upd.c0 = fresh_idx;
		end
		last_level = lvl_q == '0;
		ins_next = zero_walk_q ? ST_QUERY : ST_DONE;
		cand_left = rd_data.leaf + mxt_pkg::POS_W'(1);
		better = (acc_q > best_q) || ((acc_q == best_q) && (left_q > cand_left));

		mem_req.wr_en = 1'b0;
		mem_req.wr_addr = cur_q;
		mem_req.wr_data = entry;
		mem_req.rd_en = 1'b0;
		mem_req.rd_addr = slot;
		case (state_q)
			ST_INSERT: begin
				if (slot != '0) begin
					mem_req.rd_en = 1'b1;
				end else if (store_full) begin
					// a node made on the previous level still needs its entry
					mem_req.wr_en = fresh_q && !at_root_q;
				end else begin
					mem_req.wr_en = !at_root_q;
					mem_req.wr_data = entry_upd;
				end
			end
			ST_LEAF_WR: begin
				mem_req.wr_en = 1'b1;
			end
			ST_QUERY: begin
				mem_req.rd_en = (opp != '0) || (slot != '0);
				mem_req.rd_addr = (opp != '0) ? opp : slot;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			prefix_q <= '0;
			position_q <= '0;
			best_q <= '0;
			left_q <= mxt_pkg::POS_W'(1);
			right_q <= mxt_pkg::POS_W'(1);
			overflow_q <= 1'b0;
			last_q <= 1'b0;
			nodes_q <= mxt_pkg::COUNT_W'(1);
			root_c0_q <= '0;
			root_c1_q <= '0;
			cur_q <= '0;
			lvl_q <= '0;
			at_root_q <= 1'b1;
			fresh_q <= 1'b0;
			zero_walk_q <= 1'b0;
			acc_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						last_q <= item_last;
						if (position_q >= mxt_pkg::POS_W'(mxt_pkg::MAX_ITEMS)) begin
							overflow_q <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							position_q <= position_q + mxt_pkg::POS_W'(1);
							prefix_q <= prefix_q ^ item_value;
							lvl_q <= TOP_LVL;
							at_root_q <= 1'b1;
							fresh_q <= 1'b0;
							acc_q <= '0;
							// first item of an array: insert the empty prefix first
							zero_walk_q <= position_q == '0;
							state_q <= (position_q == '0) ? ST_INSERT : ST_QUERY;
						end
					end
				end
				ST_INSERT: begin
					if (slot != '0) begin
						cur_q <= slot;
						at_root_q <= 1'b0;
						fresh_q <= 1'b0;
						if (last_level) begin
							state_q <= ins_next;
							lvl_q <= TOP_LVL;
							at_root_q <= 1'b1;
							zero_walk_q <= 1'b0;
						end else begin
							lvl_q <= lvl_q - mxt_pkg::LVL_W'(1);
						end
					end else if (store_full) begin
						overflow_q <= 1'b1;
						state_q <= ins_next;
						lvl_q <= TOP_LVL;
						at_root_q <= 1'b1;
						fresh_q <= 1'b0;
						zero_walk_q <= 1'b0;
					end else begin
						if (at_root_q) begin
							if (bitv) begin
								root_c1_q <= fresh_idx;
							end else begin
								root_c0_q <= fresh_idx;
							end
						end
						nodes_q <= nodes_q + mxt_pkg::COUNT_W'(1);
						cur_q <= fresh_idx;
						at_root_q <= 1'b0;
						fresh_q <= 1'b1;
						if (last_level) begin
							state_q <= ST_LEAF_WR;
						end else begin
							lvl_q <= lvl_q - mxt_pkg::LVL_W'(1);
						end
					end
				end
				ST_LEAF_WR: begin
					state_q <= ins_next;
					lvl_q <= TOP_LVL;
					at_root_q <= 1'b1;
					fresh_q <= 1'b0;
					zero_walk_q <= 1'b0;
				end
				ST_QUERY: begin
					at_root_q <= 1'b0;
					if (opp != '0) begin
						cur_q <= opp;
						acc_q[lvl_q] <= 1'b1;
					end else if (slot != '0) begin
						cur_q <= slot;
					end
					if ((opp == '0) && (slot == '0)) begin
						// dead end: no partner, go straight to the insert
						state_q <= ST_INSERT;
						lvl_q <= TOP_LVL;
						at_root_q <= 1'b1;
					end else if (last_level) begin
						state_q <= ST_LEAF;
					end else begin
						lvl_q <= lvl_q - mxt_pkg::LVL_W'(1);
					end
				end
				ST_LEAF: begin
					if (better) begin
						best_q <= acc_q;
						left_q <= cand_left;
						right_q <= position_q;
					end
					state_q <= ST_INSERT;
					lvl_q <= TOP_LVL;
					at_root_q <= 1'b1;
					fresh_q <= 1'b0;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
						if (last_q) begin
							prefix_q <= '0;
							position_q <= '0;
							best_q <= '0;
							left_q <= mxt_pkg::POS_W'(1);
							right_q <= mxt_pkg::POS_W'(1);
							overflow_q <= 1'b0;
							nodes_q <= mxt_pkg::COUNT_W'(1);
							root_c0_q <= '0;
							root_c1_q <= '0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign item_ready = state_q == ST_IDLE;
	assign res_valid = state_q == ST_DONE;
	assign result.best = best_q;
	assign result.left = left_q;
	assign result.right = right_q;
	assign result.overflow = overflow_q;
	assign result.final_flag = last_q;

endmodule

`default_nettype wire

// ===== design/max_subarray_xor_trie.sv =====
`default_nettype none

// Running maximum subarray XOR. One beat in per array element, one beat out with the
// best XOR so far and its 1-based bounds; tlast on the input closes the array, is
// echoed on the output, and the block starts a fresh array after it. The trie of
// prefix XORs sits in a single-port-read node memory, one access per trie level, so
// an item steps through taking the beat, the query levels, one leaf read, the insert
// levels, one leaf write when the prefix is new and the hand-over of the result to
// the output register; the first item of each array inserts the empty prefix first.
// An item past the position limit goes straight to its result. A stalled output
// holds the result and blocks the next beat. Nothing needs clearing after reset or
// after tlast: the root is kept in flops and nodes are handed out from a fill count.
// The overflow bit sets once the node store is full or an array runs past its
// position limit.

`include "max_subarray_xor_trie_defines.svh"

module max_subarray_xor_trie (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	// value
	input  wire logic [mxt_pkg::IN_W-1:0]     s_axis_tdata,
	input  wire logic                         s_axis_tlast,
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	// best_xor, left_pos, right_pos, overflow
	output logic [mxt_pkg::OUT_W-1:0]         m_axis_tdata,
	output logic                              m_axis_tlast
);

	mxt_pkg::mem_req_t mem_req;
	mxt_pkg::node_t    rd_data;
	mxt_pkg::result_t  result;
	mxt_pkg::result_t  out_q;
	logic              out_valid_q;
	logic              res_valid;
	logic              res_ready;
	logic              in_fire;
	logic              res_fire;

	mxt_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (s_axis_tvalid),
		.item_ready (s_axis_tready),
		.item_value (s_axis_tdata[mxt_pkg::VALUE_BITS-1:0]),
		.item_last  (s_axis_tlast),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.result     (result),
		.mem_req    (mem_req),
		.rd_data    (rd_data)
	);

	mxt_node_ram u_node_ram (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign res_ready = !out_valid_q || m_axis_tready;
	assign res_fire = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_fire) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = mxt_pkg::OUT_W'({out_q.overflow, out_q.right, out_q.left, out_q.best});
	assign m_axis_tlast = out_q.final_flag;

	`MXT_ASSERT_NEXT(a_busy_after_take, in_fire, !s_axis_tready, "input taken while item in work")
	`MXT_ASSERT_IMPL(a_take_or_finish, in_fire, !res_fire, "input taken in finishing cycle")
	`MXT_ASSERT_IMPL(a_out_from_engine, $rose(out_valid_q), $past(res_fire),
		"output beat appeared without a finished item")

endmodule

`default_nettype wire
